// File: hw/rtl/cmsd_pkg.sv
// Package for the motor status frame decoder: codes, widths, kind lookup and
// the payload field decoder. No dependencies.
`timescale 1ns / 1ps

package cmsd_pkg;

    localparam int KINDS        = 5;
    localparam int ID_SLOTS     = 16;
    localparam int DEF_SLOTS    = 16;

    localparam logic [2:0] KIND_STATUS1 = 3'd0;
    localparam logic [2:0] KIND_STATUS2 = 3'd1;
    localparam logic [2:0] KIND_STATUS3 = 3'd2;
    localparam logic [2:0] KIND_STATUS4 = 3'd3;
    localparam logic [2:0] KIND_STATUS5 = 3'd4;
    localparam logic [2:0] KIND_UNKNOWN = 3'd5;

    localparam logic [7:0] CODE_STATUS1 = 8'd9;
    localparam logic [7:0] CODE_STATUS2 = 8'd14;
    localparam logic [7:0] CODE_STATUS3 = 8'd15;
    localparam logic [7:0] CODE_STATUS4 = 8'd16;
    localparam logic [7:0] CODE_STATUS5 = 8'd27;

    localparam logic [3:0] LEN_FULL  = 4'd8;
    localparam logic [3:0] LEN_SHORT = 4'd6;

    localparam logic [1:0] CFG_SLOT_COUNT = 2'd0;
    localparam logic [1:0] CFG_IDS_LOW    = 2'd1;
    localparam logic [1:0] CFG_IDS_HIGH   = 2'd2;

    localparam logic MODE_FRAME = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_DECODE
    } t_state;

    typedef struct packed {
        logic signed [31:0] v0;
        logic signed [31:0] v1;
        logic signed [15:0] v2;
        logic signed [15:0] v3;
    } t_values;

    function automatic logic [2:0] kind_of(input logic [7:0] code);
        logic [2:0] k;
        case (code)
            CODE_STATUS1: k = KIND_STATUS1;
            CODE_STATUS2: k = KIND_STATUS2;
            CODE_STATUS3: k = KIND_STATUS3;
            CODE_STATUS4: k = KIND_STATUS4;
            CODE_STATUS5: k = KIND_STATUS5;
            default:      k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

    // Big-endian fields; 16-bit fields feeding 32-bit outputs are sign-extended.
    function automatic t_values decode(input logic [63:0] p, input logic [2:0] kind);
        t_values v;
        v = '0;
        case (kind)
            KIND_STATUS1: begin
                v.v0 = p[63:32];
                v.v1 = {{16{p[31]}}, p[31:16]};
                v.v2 = p[15:0];
            end
            KIND_STATUS2, KIND_STATUS3: begin
                v.v0 = p[63:32];
                v.v1 = p[31:0];
            end
            KIND_STATUS4: begin
                v.v0 = {{16{p[63]}}, p[63:48]};
                v.v1 = {{16{p[47]}}, p[47:32]};
                v.v2 = p[31:16];
                v.v3 = p[15:0];
            end
            KIND_STATUS5: begin
                v.v0 = p[63:32];
                v.v1 = {{16{p[31]}}, p[31:16]};
            end
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/cmsd_store.sv
// Status payload store: one synchronous memory with registered read data and
// a valid bit per entry so that unwritten entries read as zero. Uses cmsd_pkg.
`timescale 1ns / 1ps

module cmsd_store #(
    parameter int DEPTH = cmsd_pkg::DEF_SLOTS * cmsd_pkg::KINDS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [63:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [63:0]   o_rdata
);
    import cmsd_pkg::*;

    logic [63:0]    r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [63:0]    r_q;
    logic           r_q_vld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_q_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_q_vld <= r_vld[i_raddr];
            end
        end
    end

    // An entry never written reads as zero, since its valid bit is still cleared from reset.
    assign o_rdata = r_q_vld ? r_q : 64'd0;

endmodule

// File: hw/rtl/can_motor_status_decoder.sv
// Top level of the motor controller status frame decoder.
// Depends on cmsd_pkg and cmsd_store.
`timescale 1ns / 1ps

// The block takes one word at a time on its input channel: either a received
// CAN frame (mode 0) or a read request (mode 1), and gives exactly one result
// word for each. For a frame, the low byte of the identifier is compared with
// the controller ids of the registered slots and the lowest matching slot wins;
// bits 15:8 select the status kind. A frame of a known kind with enough payload
// (eight bytes, or six for the fifth status kind) is written to the status store
// and its fields are returned; a read returns the fields last stored for the
// given slot and kind, or zeros if nothing was stored there. Each word passes
// two states: in the accept cycle the id search and the store write or read
// are done, and in the decode state, once the output register is free, the
// registered read data of the store is decoded into it. The output register
// lets the next word be accepted while a result still waits downstream. The
// user must write configuration through the plain write port while the block
// is idle; the block does not enforce it. No clearing pass follows reset: a
// valid bit per store entry, cleared by reset, stands for the all-zero contents.
module can_motor_status_decoder #(
    parameter int SLOTS = cmsd_pkg::DEF_SLOTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_mode,
    input  logic [28:0]        i_frame_id,
    input  logic [3:0]         i_frame_length,
    input  logic [63:0]        i_frame_data,
    input  logic [3:0]         i_read_slot,
    input  logic [2:0]         i_read_kind,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_hit,
    output logic [3:0]         o_slot,
    output logic [2:0]         o_kind,
    output logic               o_stored,
    output logic signed [31:0] o_value_0,
    output logic signed [31:0] o_value_1,
    output logic signed [15:0] o_value_2,
    output logic signed [15:0] o_value_3,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data
);
    import cmsd_pkg::*;

    // Slots beyond the sixteen ids can never match, so they get no storage.
    localparam int EFF_SLOTS = (SLOTS < ID_SLOTS) ? SLOTS : ID_SLOTS;
    localparam int DEPTH     = EFF_SLOTS * KINDS;
    localparam int AW        = $clog2(DEPTH);
    localparam logic [4:0] EFF_SLOTS5 = 5'(EFF_SLOTS);

    // Configuration registers.
    logic [4:0]   r_slot_count;
    logic [63:0]  r_ids_low;
    logic [63:0]  r_ids_high;
    logic [127:0] w_ids;
    logic [4:0]   w_n;

    // Control and captured item.
    t_state       r_state, n_state;
    logic         r_mode;
    logic         r_hit;
    logic [3:0]   r_slot;
    logic [2:0]   r_kind;
    logic         r_stored;
    logic [63:0]  r_data;

    // Output register.
    logic         r_out_valid;
    logic         w_in_acc;
    logic         w_load_out;

    // Search and address logic.
    logic         m_hit;
    logic [3:0]   m_slot;
    logic [2:0]   w_frame_kind;
    logic [2:0]   w_read_kind;
    logic         w_read_hit;
    logic         w_len_ok;
    logic         w_store_we;
    logic [3:0]   w_acc_slot;
    logic [2:0]   w_acc_kind;
    logic [6:0]   w_full_addr;
    logic [AW-1:0] w_addr;
    logic [63:0]  w_rdata;
    logic [63:0]  w_payload;
    logic         w_show;
    t_values      w_vals;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= 5'd0;
            r_ids_low    <= 64'd0;
            r_ids_high   <= 64'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SLOT_COUNT: r_slot_count <= i_cfg_data[4:0];
                CFG_IDS_LOW:    r_ids_low    <= i_cfg_data;
                CFG_IDS_HIGH:   r_ids_high   <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    assign w_ids = {r_ids_high, r_ids_low};
    assign w_n   = (r_slot_count > EFF_SLOTS5) ? EFF_SLOTS5 : r_slot_count;

    // Priority search: scanning downwards leaves the lowest matching slot.
    always_comb begin
        m_hit  = 1'b0;
        m_slot = 4'd0;
        for (int s = EFF_SLOTS - 1; s >= 0; s--) begin
            if ((5'(s) < w_n) && (w_ids[8*s +: 8] == i_frame_id[7:0])) begin
                m_hit  = 1'b1;
                m_slot = 4'(s);
            end
        end
    end

    assign w_frame_kind = kind_of(i_frame_id[15:8]);
    assign w_read_kind  = (i_read_kind < 3'(KINDS)) ? i_read_kind : KIND_UNKNOWN;
    assign w_read_hit   = ({1'b0, i_read_slot} < w_n);
    assign w_len_ok     = (w_frame_kind == KIND_STATUS5) ? (i_frame_length >= LEN_SHORT)
                                                         : (i_frame_length >= LEN_FULL);

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_store_we = w_in_acc && (i_mode == MODE_FRAME) && m_hit
                        && (w_frame_kind != KIND_UNKNOWN) && w_len_ok;

    assign w_acc_slot  = (i_mode == MODE_FRAME) ? m_slot : i_read_slot;
    assign w_acc_kind  = (i_mode == MODE_FRAME) ? w_frame_kind : w_read_kind;
    // Entry index is slot times five plus kind; out-of-range reads are masked later.
    assign w_full_addr = 7'(w_acc_slot) * 7'(KINDS) + 7'(w_acc_kind);
    assign w_addr      = w_full_addr[AW-1:0];

    cmsd_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_store_we),
        .i_waddr (w_addr),
        .i_wdata (i_frame_data),
        .i_re    (w_in_acc && (i_mode == MODE_READ)),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_mode   <= i_mode;
            r_hit    <= (i_mode == MODE_FRAME) ? m_hit : w_read_hit;
            r_slot   <= w_acc_slot;
            r_kind   <= w_acc_kind;
            r_stored <= w_store_we;
            r_data   <= i_frame_data;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_in_ready = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            ST_IDLE:   o_in_ready = 1'b1;
            ST_DECODE: w_load_out = !r_out_valid || i_out_ready;
            default:   ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Frames show their own payload once stored; reads show the store contents.
    assign w_payload = (r_mode == MODE_READ) ? w_rdata : r_data;
    assign w_show    = (r_mode == MODE_READ) ? (r_hit && (r_kind != KIND_UNKNOWN)) : r_stored;
    assign w_vals    = w_show ? decode(w_payload, r_kind) : '0;

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            o_hit     <= r_hit;
            o_slot    <= (r_mode == MODE_FRAME && !r_hit) ? 4'd0 : r_slot;
            o_kind    <= r_kind;
            o_stored  <= r_stored;
            o_value_0 <= w_vals.v0;
            o_value_1 <= w_vals.v1;
            o_value_2 <= w_vals.v2;
            o_value_3 <= w_vals.v3;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_stored_has_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_stored |-> o_hit && (o_kind != KIND_UNKNOWN))
        else $error("stored result without a hit of a known kind");

    a_unknown_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_UNKNOWN)
            |-> (o_value_0 == 0) && (o_value_1 == 0) && (o_value_2 == 0) && (o_value_3 == 0))
        else $error("unknown kind gave non-zero values");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_hit |-> (o_value_0 == 0) && (o_value_1 == 0) && !o_stored)
        else $error("miss gave non-zero values");

    a_decode_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DECODE) && w_load_out |=> (r_state == ST_IDLE) && r_out_valid)
        else $error("decoded word not loaded into the output register");

    a_write_only_on_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_store_we |-> w_in_acc && (i_mode == MODE_FRAME) && (w_full_addr < 7'(DEPTH)))
        else $error("store write outside a frame or beyond the store");
`endif

endmodule

// File: sim/tb_can_motor_status_decoder.sv
// Self-checking testbench for can_motor_status_decoder: a directed table and random
// phases, every result word compared with a table expectation or an in-bench model.
// Depends on cmsd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_can_motor_status_decoder;
    import cmsd_pkg::*;

    // Codes and read kinds that the decoder must treat as unknown.
    localparam logic [7:0] CODE_UNLISTED = 8'h0A;
    localparam logic [2:0] READ_KIND_BAD_LO = 3'd5;
    localparam logic [2:0] READ_KIND_BAD_HI = 3'd7;

    localparam int PHASES        = 8;
    localparam int WORDS_PER_PHASE = 50;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 16;

    typedef struct packed {
        logic        mode;
        logic [28:0] id;
        logic [3:0]  len;
        logic [63:0] data;
        logic [3:0]  rslot;
        logic [2:0]  rkind;
    } t_frame_word;

    typedef struct packed {
        logic               hit;
        logic [3:0]         slot;
        logic [2:0]         kind;
        logic               stored;
        logic signed [31:0] v0;
        logic signed [31:0] v1;
        logic signed [15:0] v2;
        logic signed [15:0] v3;
    } t_status_result;

    typedef enum logic {
        ROW_CFG,
        ROW_WORD
    } t_row_kind;

    typedef struct {
        t_row_kind      what;
        logic [1:0]     cfg_idx;
        logic [63:0]    cfg_data;
        t_frame_word    word;
        bit             has_exp;
        t_status_result exp_r;
    } t_table_row;

    // Clock, reset and the signals of the decoder.
    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               mode = 1'b0;
    logic [28:0]        frame_id = '0;
    logic [3:0]         frame_length = '0;
    logic [63:0]        frame_data = '0;
    logic [3:0]         read_slot = '0;
    logic [2:0]         read_kind = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               hit;
    logic [3:0]         slot;
    logic [2:0]         kind;
    logic               stored;
    logic signed [31:0] value_0;
    logic signed [31:0] value_1;
    logic signed [15:0] value_2;
    logic signed [15:0] value_3;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [63:0]        cfg_data = '0;

    // Model copy of the registers and of the status store.
    logic [4:0]  slot_count_m = '0;
    logic [63:0] ids_low_m = '0;
    logic [63:0] ids_high_m = '0;
    logic [63:0] status_mem_m [DEF_SLOTS*KINDS];

    t_status_result pending_results [$];
    t_table_row     directed_rows [$];
    int             mismatch_count = 0;

    // Idling controls, set by the stimulus process and read by the two sides.
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  start_hold = 1'b0;
    bit  hold_taken = 1'b0;
    int  hold_left = 0;

    logic [7:0] known_codes [5] = '{CODE_STATUS1, CODE_STATUS2, CODE_STATUS3,
                                    CODE_STATUS4, CODE_STATUS5};

    can_motor_status_decoder i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_mode         (mode),
        .i_frame_id     (frame_id),
        .i_frame_length (frame_length),
        .i_frame_data   (frame_data),
        .i_read_slot    (read_slot),
        .i_read_kind    (read_kind),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_hit          (hit),
        .o_slot         (slot),
        .o_kind         (kind),
        .o_stored       (stored),
        .o_value_0      (value_0),
        .o_value_1      (value_1),
        .o_value_2      (value_2),
        .o_value_3      (value_3),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------

    // Values of slot_count above the number of id slots act as sixteen.
    function automatic int unsigned active_slot_total();
        return (slot_count_m > 5'd16) ? 16 : int'(slot_count_m);
    endfunction

    function automatic logic [7:0] slot_ctrl_id(input int s);
        logic [63:0] ids;
        ids = (s < 8) ? ids_low_m : ids_high_m;
        return ids[8*(s%8) +: 8];
    endfunction

    function automatic logic [2:0] code_to_kind(input logic [7:0] code);
        logic [2:0] k;
        case (code)
            CODE_STATUS1: k = KIND_STATUS1;
            CODE_STATUS2: k = KIND_STATUS2;
            CODE_STATUS3: k = KIND_STATUS3;
            CODE_STATUS4: k = KIND_STATUS4;
            CODE_STATUS5: k = KIND_STATUS5;
            default:      k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

    // Fills in the big-endian fields of a stored payload. Sixteen-bit fields
    // that land on a 32-bit output are sign-extended; the 16-bit outputs take
    // the raw pair.
    function automatic t_status_result with_payload_fields(input t_status_result r,
                                                           input logic [63:0] p,
                                                           input logic [2:0] k);
        t_status_result o;
        o = r;
        o.v0 = '0;
        o.v1 = '0;
        o.v2 = '0;
        o.v3 = '0;
        case (k)
            KIND_STATUS1: begin
                o.v0 = p[63:32];
                o.v1 = 32'($signed(p[31:16]));
                o.v2 = p[15:0];
            end
            KIND_STATUS2, KIND_STATUS3: begin
                o.v0 = p[63:32];
                o.v1 = p[31:0];
            end
            KIND_STATUS4: begin
                o.v0 = 32'($signed(p[63:48]));
                o.v1 = 32'($signed(p[47:32]));
                o.v2 = p[31:16];
                o.v3 = p[15:0];
            end
            KIND_STATUS5: begin
                o.v0 = p[63:32];
                o.v1 = 32'($signed(p[31:16]));
            end
            default: begin
            end
        endcase
        return o;
    endfunction

    // Works out the result word of one accepted input word and applies any
    // store write it causes.
    function automatic t_status_result predict_status_result(input t_frame_word w);
        t_status_result r;
        int unsigned    n;
        logic [2:0]     k;
        logic [3:0]     need;
        int             entry;
        r = '0;
        n = active_slot_total();
        if (w.mode == MODE_FRAME) begin
            k = code_to_kind(w.id[15:8]);
            r.kind = k;
            // The lowest slot whose id matches wins.
            for (int s = 0; s < int'(n); s++) begin
                if (!r.hit && slot_ctrl_id(s) == w.id[7:0]) begin
                    r.hit = 1'b1;
                    r.slot = s[3:0];
                end
            end
            if (r.hit && k != KIND_UNKNOWN) begin
                need = (k == KIND_STATUS5) ? LEN_SHORT : LEN_FULL;
                if (w.len >= need) begin
                    entry = int'(r.slot) * KINDS + int'(k);
                    status_mem_m[entry] = w.data;
                    r.stored = 1'b1;
                    r = with_payload_fields(r, w.data, k);
                end
            end
        end else begin
            r.slot = w.rslot;
            r.kind = (int'(w.rkind) < KINDS) ? w.rkind : KIND_UNKNOWN;
            r.hit = (int'(w.rslot) < int'(n));
            if (r.hit && r.kind != KIND_UNKNOWN) begin
                entry = int'(r.slot) * KINDS + int'(r.kind);
                r = with_payload_fields(r, status_mem_m[entry], r.kind);
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_frame_word mk_frame(input logic [7:0] code, input logic [7:0] ctrl,
                                             input logic [3:0] len, input logic [63:0] data,
                                             input logic [12:0] upper);
        t_frame_word w;
        w = '0;
        w.mode = MODE_FRAME;
        w.id = {upper, code, ctrl};
        w.len = len;
        w.data = data;
        return w;
    endfunction

    function automatic t_frame_word mk_read(input logic [3:0] s, input logic [2:0] k);
        t_frame_word w;
        w = '0;
        w.mode = MODE_READ;
        w.rslot = s;
        w.rkind = k;
        return w;
    endfunction

    function automatic t_status_result mk_result(input logic h, input logic [3:0] s,
                                                 input logic [2:0] k, input logic st,
                                                 input int v0, input int v1,
                                                 input int v2, input int v3);
        t_status_result r;
        r.hit = h;
        r.slot = s;
        r.kind = k;
        r.stored = st;
        r.v0 = v0;
        r.v1 = v1;
        r.v2 = v2[15:0];
        r.v3 = v3[15:0];
        return r;
    endfunction

    task automatic add_cfg(input logic [1:0] idx, input logic [63:0] data);
        t_table_row row;
        row.what = ROW_CFG;
        row.cfg_idx = idx;
        row.cfg_data = data;
        row.word = '0;
        row.has_exp = 1'b0;
        row.exp_r = '0;
        directed_rows.push_back(row);
    endtask

    task automatic add_word(input t_frame_word w, input bit has_exp,
                            input t_status_result e);
        t_table_row row;
        row.what = ROW_WORD;
        row.cfg_idx = '0;
        row.cfg_data = '0;
        row.word = w;
        row.has_exp = has_exp;
        row.exp_r = e;
        directed_rows.push_back(row);
    endtask

    // Controller id bytes: half of them from a narrow pool so that duplicate
    // ids, and hence the lowest-slot rule, come up often.
    function automatic logic [63:0] random_id_bytes();
        logic [63:0] ids;
        for (int b = 0; b < 8; b++) begin
            if ($urandom_range(0, 1) == 0) begin
                ids[8*b +: 8] = 8'($urandom_range(0, 7));
            end else begin
                ids[8*b +: 8] = 8'($urandom_range(0, 255));
            end
        end
        return ids;
    endfunction

    // Random word. Most frames carry a registered id, a known code and a long
    // enough payload so that they reach the store; the rest is noise.
    function automatic t_frame_word random_status_word();
        t_frame_word w;
        int unsigned n;
        int          s;
        w.mode = ($urandom_range(0, 99) < 30) ? MODE_READ : MODE_FRAME;
        w.id = 29'($urandom);
        w.len = 4'($urandom_range(0, 15));
        w.data = {$urandom, $urandom};
        w.rslot = 4'($urandom_range(0, 15));
        w.rkind = 3'($urandom_range(0, 7));
        n = active_slot_total();
        if (w.mode == MODE_FRAME) begin
            if ($urandom_range(0, 99) < 85) begin
                w.id[15:8] = known_codes[$urandom_range(0, 4)];
            end
            if (n > 0 && $urandom_range(0, 99) < 80) begin
                s = $urandom_range(0, n - 1);
                w.id[7:0] = slot_ctrl_id(s);
            end
            if ($urandom_range(0, 99) < 75) begin
                w.len = 4'($urandom_range(8, 15));
            end
        end else if ($urandom_range(0, 99) < 80) begin
            w.rkind = 3'($urandom_range(0, 4));
        end
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Offers one word, after any random idle gap, from a falling edge and returns
    // just after the rising edge that accepted it. Valid is left high so that a
    // following word can go out without a gap.
    task automatic send_word(input t_frame_word w, input bit has_exp,
                             input t_status_result e);
        t_status_result predicted;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        mode <= w.mode;
        frame_id <= w.id;
        frame_length <= w.len;
        frame_data <= w.data;
        read_slot <= w.rslot;
        read_kind <= w.rkind;
        do begin
            @(posedge clk);
        end while (!in_ready);
        predicted = predict_status_result(w);
        pending_results.push_back(has_exp ? e : predicted);
    endtask

    // Withdraws valid and waits for every expected word to come out.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_SLOT_COUNT: slot_count_m = data[4:0];
            CFG_IDS_LOW:    ids_low_m = data;
            CFG_IDS_HIGH:   ids_high_m = data;
            default: begin
            end
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Receiver side: random stalls, plus one long hold-off that is counted
    // here, so that the output register and then the input side back up.
    always @(negedge clk) begin
        if (start_hold && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = LONG_HOLD;
        end
        if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic signed [63:0] e,
                               input logic signed [63:0] a);
        if (e !== a) begin
            $error("%s: expected %0d, got %0d", name, e, a);
            mismatch_count++;
        end
    endtask

    always @(posedge clk) begin : result_check
        t_status_result exp_r;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with no expectation waiting");
                mismatch_count++;
            end else begin
                exp_r = pending_results.pop_front();
                check_field("hit", {63'd0, exp_r.hit}, {63'd0, hit});
                check_field("slot", {60'd0, exp_r.slot}, {60'd0, slot});
                check_field("kind", {61'd0, exp_r.kind}, {61'd0, kind});
                check_field("stored", {63'd0, exp_r.stored}, {63'd0, stored});
                check_field("value_0", 64'(exp_r.v0), 64'(value_0));
                check_field("value_1", 64'(exp_r.v1), 64'(value_1));
                check_field("value_2", 64'(exp_r.v2), 64'(value_2));
                check_field("value_3", 64'(exp_r.v3), 64'(value_3));
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial begin
        logic [4:0] count_pick;
        for (int i = 0; i < DEF_SLOTS * KINDS; i++) begin
            status_mem_m[i] = '0;
        end

        // Straight after reset no slot is registered, so nothing can match
        // and every read is out of range.
        add_word(mk_read(4'd0, KIND_STATUS1), 1'b1,
                 mk_result(1'b0, 4'd0, KIND_STATUS1, 1'b0, 0, 0, 0, 0));
        add_word(mk_frame(CODE_STATUS1, 8'h00, LEN_FULL, '1, '0), 1'b1,
                 mk_result(1'b0, 4'd0, KIND_STATUS1, 1'b0, 0, 0, 0, 0));

        // All sixteen slots; slot 8 repeats the id of slot 1.
        add_cfg(CFG_SLOT_COUNT, 64'd16);
        add_cfg(CFG_IDS_LOW, 64'h7766_5544_3322_1100);
        add_cfg(CFG_IDS_HIGH, 64'hFFEE_DDCC_BBAA_9911);
        add_word(mk_frame(CODE_STATUS1, 8'h22, LEN_FULL, '1, '0), 1'b1,
                 mk_result(1'b1, 4'd2, KIND_STATUS1, 1'b1, -1, -1, -1, 0));
        add_word(mk_read(4'd2, KIND_STATUS1), 1'b0, '0);
        add_word(mk_frame(CODE_STATUS4, 8'hFF, LEN_FULL, 64'h8000_7FFF_8000_7FFF, '0),
                 1'b1, mk_result(1'b1, 4'd15, KIND_STATUS4, 1'b1,
                                 -32768, 32767, -32768, 32767));
        // Duplicate id: slot 1 wins over slot 8. Six bytes are enough here.
        add_word(mk_frame(CODE_STATUS5, 8'h11, LEN_SHORT, 64'h7FFF_FFFF_8000_1234, '0),
                 1'b0, '0);
        // Short payloads leave the store alone and return zeros.
        add_word(mk_frame(CODE_STATUS5, 8'h11, 4'd5, '1, '0), 1'b1,
                 mk_result(1'b1, 4'd1, KIND_STATUS5, 1'b0, 0, 0, 0, 0));
        add_word(mk_frame(CODE_STATUS1, 8'h33, 4'd7, '1, '0), 1'b1,
                 mk_result(1'b1, 4'd3, KIND_STATUS1, 1'b0, 0, 0, 0, 0));
        // Unknown command on a registered controller.
        add_word(mk_frame(CODE_UNLISTED, 8'h00, LEN_FULL, '1, '0), 1'b1,
                 mk_result(1'b1, 4'd0, KIND_UNKNOWN, 1'b0, 0, 0, 0, 0));
        add_word(mk_frame(CODE_STATUS2, 8'h99, 4'd15, 64'h0123_4567_89AB_CDEF, '0),
                 1'b0, '0);
        // Controller id that no slot holds.
        add_word(mk_frame(CODE_STATUS3, 8'h42, LEN_FULL, '1, '0), 1'b1,
                 mk_result(1'b0, 4'd0, KIND_STATUS3, 1'b0, 0, 0, 0, 0));
        add_word(mk_frame(CODE_STATUS3, 8'h00, LEN_FULL, 64'hFEDC_BA98_7654_3210, '1),
                 1'b0, '0);
        add_word(mk_read(4'd15, KIND_STATUS4), 1'b0, '0);
        add_word(mk_read(4'd0, READ_KIND_BAD_LO), 1'b1,
                 mk_result(1'b1, 4'd0, KIND_UNKNOWN, 1'b0, 0, 0, 0, 0));
        add_word(mk_read(4'd3, READ_KIND_BAD_HI), 1'b1,
                 mk_result(1'b1, 4'd3, KIND_UNKNOWN, 1'b0, 0, 0, 0, 0));
        add_word(mk_read(4'd1, KIND_STATUS5), 1'b0, '0);
        add_word(mk_read(4'd9, KIND_STATUS2), 1'b0, '0);
        add_word(mk_read(4'd0, KIND_STATUS3), 1'b0, '0);

        // A count above sixteen acts as sixteen; ids at their extremes.
        add_cfg(CFG_SLOT_COUNT, 64'd31);
        add_cfg(CFG_IDS_LOW, '1);
        add_cfg(CFG_IDS_HIGH, '0);
        add_word(mk_frame(CODE_STATUS1, 8'hFF, LEN_FULL, 64'h8000_0000_7FFF_0001, '0),
                 1'b0, '0);
        add_word(mk_frame(CODE_STATUS2, 8'h00, LEN_FULL, 64'h8000_0000_0000_0001, '0),
                 1'b0, '0);
        add_word(mk_read(4'd15, KIND_STATUS4), 1'b0, '0);

        // Only slot 0 is left; slot 1 reads fall out of range.
        add_cfg(CFG_SLOT_COUNT, 64'd1);
        add_word(mk_read(4'd1, KIND_STATUS1), 1'b1,
                 mk_result(1'b0, 4'd1, KIND_STATUS1, 1'b0, 0, 0, 0, 0));
        add_word(mk_frame(CODE_STATUS4, 8'h00, LEN_FULL, '1, '0), 1'b1,
                 mk_result(1'b0, 4'd0, KIND_STATUS4, 1'b0, 0, 0, 0, 0));

        // Synchronous reset held, then released on a falling edge.
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].what == ROW_CFG) begin
                wait_drained();
                write_reg(directed_rows[r].cfg_idx, directed_rows[r].cfg_data);
            end else begin
                send_word(directed_rows[r].word, directed_rows[r].has_exp,
                          directed_rows[r].exp_r);
            end
        end

        // Random phases, each with its own register setting and idling mix.
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            case (ph)
                0, 4:    count_pick = 5'd16;
                1:       count_pick = 5'($urandom_range(1, 15));
                2:       count_pick = 5'd31;
                3:       count_pick = 5'd1;
                5:       count_pick = 5'($urandom_range(17, 30));
                6:       count_pick = 5'($urandom_range(2, 15));
                default: count_pick = 5'd0;
            endcase
            write_reg(CFG_SLOT_COUNT, {59'd0, count_pick});
            write_reg(CFG_IDS_LOW, random_id_bytes());
            write_reg(CFG_IDS_HIGH, random_id_bytes());
            case (ph % 4)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 64;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 64;
                end
                default: begin
                    send_idle_pct = 18;
                    recv_stall_pct = 18;
                end
            endcase
            for (int i = 0; i < WORDS_PER_PHASE; i++) begin
                // The receiver holds off while words keep coming.
                if (ph == 0 && i == 10) begin
                    start_hold = 1'b1;
                end
                // The sender stops until every result so far has come out.
                if (ph == 1 && i == WORDS_PER_PHASE / 2) begin
                    wait_drained();
                end
                send_word(random_status_word(), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_results.size() != 0) begin
            $error("%0d result words never arrived", pending_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("[can_motor_status_decoder] OK");
        end else begin
            $display("[can_motor_status_decoder] ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("[can_motor_status_decoder] ERROR");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/cmsd_pkg.sv
hw/rtl/cmsd_store.sv
hw/rtl/can_motor_status_decoder.sv
sim/tb_can_motor_status_decoder.sv
